// ===== rtl/rps_automaton_cell_update_core_assert.svh =====
// Assertion macros shared by the cell update core modules.
`ifndef RPS_AUTOMATON_CELL_UPDATE_CORE_ASSERT_SVH
`define RPS_AUTOMATON_CELL_UPDATE_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clock, off while reset is high.
`define RPSACU_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off while reset is high.
`define RPSACU_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rpsacu_pkg.sv =====
// Types, constants and channel arithmetic for the cell update core.
package rpsacu_pkg;

   // Field widths
   localparam int IDX_W       = 9;
   localparam int CELL_W      = 24;
   localparam int CHAN_W      = 8;
   localparam int FUNC_W      = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   // Neighbour sums: nine reads of up to 255 each
   localparam int SUM_W = 12;
   localparam int ACC_W = SUM_W + 3;

   // Read sequence: nine neighbour reads, then the centre
   localparam int NBR_READS  = 10;
   localparam int NBR_SEL_W  = 4;
   localparam int NBR_CENTRE = 9;
   localparam int DRAIN_LAST = 1;

   typedef enum logic [FUNC_W-1:0] {
      FN_LOAD    = 2'd0,
      FN_COMPUTE = 2'd1,
      FN_COMMIT  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      OFS_ZERO  = 2'd0,
      OFS_MINUS = 2'd1,
      OFS_PLUS  = 2'd2
   } ofs_type;

   // (+1,+1) appears twice; the last entry is the centre
   localparam ofs_type NBR_DX [NBR_READS] = '{
      OFS_MINUS, OFS_MINUS, OFS_MINUS, OFS_ZERO, OFS_ZERO,
      OFS_PLUS,  OFS_PLUS,  OFS_PLUS,  OFS_PLUS, OFS_ZERO
   };
   localparam ofs_type NBR_DY [NBR_READS] = '{
      OFS_MINUS, OFS_ZERO,  OFS_PLUS,  OFS_MINUS, OFS_PLUS,
      OFS_MINUS, OFS_ZERO,  OFS_PLUS,  OFS_PLUS,  OFS_ZERO
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVY,
      ST_DIVX,
      ST_READ,
      ST_DRAIN,
      ST_QUOT,
      ST_RESULT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic                 capture;
      logic                 load_we;
      logic                 commit;
      logic                 clear_sums;
      logic                 ydiv;
      logic                 xdiv;
      logic                 nbr_issue;
      logic [NBR_SEL_W-1:0] nbr_sel;
      logic                 quot;
      logic                 result;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

   // chan - loss + gain, clamped to 0..255
   function automatic logic [CHAN_W-1:0] apply_rate(
      input logic [CHAN_W-1:0] chan,
      input logic [SUM_W-1:0]  loss,
      input logic [SUM_W-1:0]  gain
   );
      logic [ACC_W-1:0] acc;
      acc = {{(ACC_W-CHAN_W){1'b0}}, chan} - {3'b000, loss} + {3'b000, gain};
      if (acc[ACC_W-1]) begin
         apply_rate = '0;
      end else if (|acc[ACC_W-2:CHAN_W]) begin
         apply_rate = '1;
      end else begin
         apply_rate = acc[CHAN_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/rps_automaton_cell_update_core.sv =====
// Top level of the rock-paper-scissors cell update core.
// Load, compute and commit items arrive on req_; a compute returns one item on rsp_.
// Loads and commits are done as they are accepted. After an in-range compute is
// accepted the block is busy and accepts no new item while it derives the cell
// coordinates, issues the nine neighbour reads and the centre read on the single
// port of the cell memory, drains the read pipeline, divides the sums and writes
// the result to the other bank and to the output register. The output register
// holds a finished item while the next one is accepted; a compute only waits at
// its last step if that register is still full.
// Cell memory contents are undefined after reset until loaded; there is no
// clearing pass. Out-of-range load and compute indexes and the unused function
// code do nothing.
module rps_automaton_cell_update_core #(
   parameter int GRID_WIDTH   = 31,
   parameter int GRID_HEIGHT  = 16,
   parameter int RATE_DIVISOR = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // cell_index [8:0], cell_value [32:9]
   input  logic [rpsacu_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // func [1:0]
   input  logic [rpsacu_pkg::FUNC_W-1:0]         req_tuser,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // out_index [8:0], new_cell_value [32:9]
   output logic [rpsacu_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready
);

   localparam int PAD_W = rpsacu_pkg::RSP_TDATA_W - rpsacu_pkg::IDX_W - rpsacu_pkg::CELL_W;

   rpsacu_pkg::cmd_type                 cmd;
   rpsacu_pkg::status_type              status;
   logic [rpsacu_pkg::IDX_W-1:0]        req_cell_index;
   logic [rpsacu_pkg::CELL_W-1:0]       req_cell_value;
   logic [rpsacu_pkg::IDX_W-1:0]        rsp_index;
   logic [rpsacu_pkg::CELL_W-1:0]       rsp_value;

   // Unpack the request item
   assign req_cell_index = req_tdata[rpsacu_pkg::IDX_W-1:0];
   assign req_cell_value = req_tdata[rpsacu_pkg::IDX_W +: rpsacu_pkg::CELL_W];

   rpsacu_ctrl #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_func       (req_tuser),
      .req_cell_index (req_cell_index),
      .status         (status),
      .cmd            (cmd)
   );

   rpsacu_datapath #(
      .GRID_WIDTH   (GRID_WIDTH),
      .GRID_HEIGHT  (GRID_HEIGHT),
      .RATE_DIVISOR (RATE_DIVISOR)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_cell_index (req_cell_index),
      .req_cell_value (req_cell_value),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_index      (rsp_index),
      .rsp_value      (rsp_value)
   );

   // Pack the result item
   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_value, rsp_index};

endmodule

// ===== rtl/rpsacu_ram.sv =====
// Generic single-port RAM with registered read.
module rpsacu_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, or read into the output register
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rpsacu_ctrl.sv =====
// Sequencer for load, commit and the compute read sequence.
module rpsacu_ctrl #(
   parameter int GRID_WIDTH  = 31,
   parameter int GRID_HEIGHT = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rpsacu_pkg::FUNC_W-1:0]   req_func,
   input  logic [rpsacu_pkg::IDX_W-1:0]    req_cell_index,
   input  rpsacu_pkg::status_type          status,
   output rpsacu_pkg::cmd_type             cmd
);

   `include "rps_automaton_cell_update_core_assert.svh"

   localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;

   rpsacu_pkg::state_type                    state_ff, state_in;
   logic [rpsacu_pkg::NBR_SEL_W-1:0]         cnt_ff, cnt_in;
   logic                                     accept;
   logic                                     in_range;
   rpsacu_pkg::func_type                     func;

   assign func     = rpsacu_pkg::func_type'(req_func);
   assign in_range = {{(32-rpsacu_pkg::IDX_W){1'b0}}, req_cell_index} < 32'(CELL_COUNT);
   assign accept   = req_tvalid && req_tready;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpsacu_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = '0;
      case (state_ff)
         rpsacu_pkg::ST_IDLE: begin
            if (accept && func == rpsacu_pkg::FN_COMPUTE && in_range) begin
               state_in = rpsacu_pkg::ST_DIVY;
            end
         end
         rpsacu_pkg::ST_DIVY: state_in = rpsacu_pkg::ST_DIVX;
         rpsacu_pkg::ST_DIVX: state_in = rpsacu_pkg::ST_READ;
         rpsacu_pkg::ST_READ: begin
            if (cnt_ff == rpsacu_pkg::NBR_SEL_W'(rpsacu_pkg::NBR_READS - 1)) begin
               state_in = rpsacu_pkg::ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         rpsacu_pkg::ST_DRAIN: begin
            if (cnt_ff == rpsacu_pkg::NBR_SEL_W'(rpsacu_pkg::DRAIN_LAST)) begin
               state_in = rpsacu_pkg::ST_QUOT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         rpsacu_pkg::ST_QUOT: state_in = rpsacu_pkg::ST_RESULT;
         rpsacu_pkg::ST_RESULT: begin
            if (status.out_free) begin
               state_in = rpsacu_pkg::ST_IDLE;
            end
         end
         default: state_in = rpsacu_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready     = (state_ff == rpsacu_pkg::ST_IDLE);
      cmd            = '0;
      cmd.capture    = accept;
      cmd.nbr_sel    = cnt_ff;
      case (state_ff)
         rpsacu_pkg::ST_IDLE: begin
            if (accept) begin
               case (func)
                  rpsacu_pkg::FN_LOAD:   cmd.load_we = in_range;
                  rpsacu_pkg::FN_COMMIT: cmd.commit  = 1'b1;
                  default:               ;
               endcase
            end
         end
         rpsacu_pkg::ST_DIVY: begin
            cmd.clear_sums = 1'b1;
            cmd.ydiv       = 1'b1;
         end
         rpsacu_pkg::ST_DIVX:   cmd.xdiv      = 1'b1;
         rpsacu_pkg::ST_READ:   cmd.nbr_issue = 1'b1;
         rpsacu_pkg::ST_QUOT:   cmd.quot      = 1'b1;
         rpsacu_pkg::ST_RESULT: cmd.result    = status.out_free;
         default:               ;
      endcase
   end

   // Checks
   `RPSACU_ASSERT_NXT(a_compute_starts,
      accept && func == rpsacu_pkg::FN_COMPUTE && in_range,
      state_ff == rpsacu_pkg::ST_DIVY, "in-range compute item did not start")
   `RPSACU_ASSERT_IMP(a_read_count,
      state_ff == rpsacu_pkg::ST_READ,
      cnt_ff < rpsacu_pkg::NBR_SEL_W'(rpsacu_pkg::NBR_READS), "read count overran")
   `RPSACU_ASSERT_NXT(a_drain_done,
      state_ff == rpsacu_pkg::ST_DRAIN && cnt_ff == rpsacu_pkg::NBR_SEL_W'(rpsacu_pkg::DRAIN_LAST),
      state_ff == rpsacu_pkg::ST_QUOT, "drain did not end in the quotient step")

endmodule

// ===== rtl/rpsacu_datapath.sv =====
// Cell memory, coordinate unit, neighbour accumulators and result register.
module rpsacu_datapath #(
   parameter int GRID_WIDTH   = 31,
   parameter int GRID_HEIGHT  = 16,
   parameter int RATE_DIVISOR = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rpsacu_pkg::cmd_type             cmd,
   output rpsacu_pkg::status_type          status,
   input  logic [rpsacu_pkg::IDX_W-1:0]    req_cell_index,
   input  logic [rpsacu_pkg::CELL_W-1:0]   req_cell_value,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [rpsacu_pkg::IDX_W-1:0]    rsp_index,
   output logic [rpsacu_pkg::CELL_W-1:0]   rsp_value
);

   `include "rps_automaton_cell_update_core_assert.svh"

   localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int XW         = $clog2(GRID_WIDTH);
   localparam int YW         = $clog2(GRID_HEIGHT);
   localparam int RAM_DEPTH  = 2 * (1 << AW);
   localparam int SUM_W      = rpsacu_pkg::SUM_W;
   localparam int CHAN_W     = rpsacu_pkg::CHAN_W;

   // Row from index by reciprocal multiply, exact for every index below 2**AW
   localparam int KY = AW + $clog2(GRID_WIDTH) + 1;
   localparam longint unsigned MY = ((64'd1 << KY) + GRID_WIDTH - 1) / GRID_WIDTH;
   localparam int PY = AW + KY + 1;

   // Division of a sum by the rate divisor, exact for every sum below 2**SUM_W
   localparam int KD = SUM_W + $clog2(RATE_DIVISOR) + 1;
   localparam longint unsigned MD = ((64'd1 << KD) + RATE_DIVISOR - 1) / RATE_DIVISOR;
   localparam int PD = SUM_W + KD + 1;

   logic                            bank_ff, bank_in;
   logic [rpsacu_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [AW-1:0]                   idx_cell;
   logic [YW-1:0]                   y_ff, y_in;
   logic [XW-1:0]                   x_ff, x_in;
   logic [PY-1:0]                   yprod;
   logic [AW-1:0]                   rowbase;
   logic [XW-1:0]                   nx;
   logic [YW-1:0]                   ny;
   logic [AW-1:0]                   addr_ff, addr_in;
   logic                            av_ff, actr_ff, actr_in;
   logic                            rv_ff, rctr_ff;
   logic [rpsacu_pkg::CELL_W-1:0]   rd_data;
   logic [SUM_W-1:0]                rs_ff, ps_ff, ss_ff, rs_in, ps_in, ss_in;
   logic [rpsacu_pkg::CELL_W-1:0]   centre_ff, centre_in;
   logic [PD-1:0]                   pr, pp, ps;
   logic [SUM_W-1:0]                qr_ff, qp_ff, qs_ff, qr_in, qp_in, qs_in;
   logic [rpsacu_pkg::CELL_W-1:0]   new_value;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rpsacu_pkg::IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [rpsacu_pkg::CELL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                            ram_we;
   logic [AW:0]                     ram_addr;
   logic [rpsacu_pkg::CELL_W-1:0]   ram_wr_data;

   assign idx_cell = AW'(idx_ff);

   // Bank select and captured index
   always_comb begin
      bank_in = cmd.commit ? ~bank_ff : bank_ff;
      idx_in  = cmd.capture ? req_cell_index : idx_ff;
   end

   // Coordinates: row first, then column from the row base
   assign yprod   = PY'(idx_cell) * PY'(MY);
   assign rowbase = AW'(AW'(y_ff) * AW'(GRID_WIDTH));
   always_comb begin
      y_in = cmd.ydiv ? YW'(yprod >> KY) : y_ff;
      x_in = cmd.xdiv ? XW'(idx_cell - rowbase) : x_ff;
   end

   // Neighbour column with wraparound
   always_comb begin
      case (rpsacu_pkg::NBR_DX[cmd.nbr_sel])
         rpsacu_pkg::OFS_MINUS: nx = (x_ff == '0) ? XW'(GRID_WIDTH - 1) : x_ff - 1'b1;
         rpsacu_pkg::OFS_PLUS:  nx = (x_ff == XW'(GRID_WIDTH - 1)) ? '0 : x_ff + 1'b1;
         default:               nx = x_ff;
      endcase
   end

   // Neighbour row with wraparound
   always_comb begin
      case (rpsacu_pkg::NBR_DY[cmd.nbr_sel])
         rpsacu_pkg::OFS_MINUS: ny = (y_ff == '0) ? YW'(GRID_HEIGHT - 1) : y_ff - 1'b1;
         rpsacu_pkg::OFS_PLUS:  ny = (y_ff == YW'(GRID_HEIGHT - 1)) ? '0 : y_ff + 1'b1;
         default:               ny = y_ff;
      endcase
   end

   // Read address stage
   assign addr_in = AW'(nx) + AW'(AW'(ny) * AW'(GRID_WIDTH));
   assign actr_in = (cmd.nbr_sel == rpsacu_pkg::NBR_SEL_W'(rpsacu_pkg::NBR_CENTRE));

   // Memory port: loads and results write, otherwise read the current bank
   always_comb begin
      ram_we      = cmd.load_we || cmd.result;
      ram_wr_data = cmd.load_we ? req_cell_value : new_value;
      if (cmd.load_we) begin
         ram_addr = {bank_ff, AW'(req_cell_index)};
      end else if (cmd.result) begin
         ram_addr = {~bank_ff, idx_cell};
      end else begin
         ram_addr = {bank_ff, addr_ff};
      end
   end

   rpsacu_ram #(
      .WIDTH (rpsacu_pkg::CELL_W),
      .DEPTH (RAM_DEPTH)
   ) u_cells (
      .clock   (clock),
      .we      (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (rd_data)
   );

   // Channel accumulators and centre capture
   always_comb begin
      rs_in     = rs_ff;
      ps_in     = ps_ff;
      ss_in     = ss_ff;
      centre_in = centre_ff;
      if (cmd.clear_sums) begin
         rs_in = '0;
         ps_in = '0;
         ss_in = '0;
      end else if (rv_ff && rctr_ff) begin
         centre_in = rd_data;
      end else if (rv_ff) begin
         rs_in = rs_ff + SUM_W'(rd_data[23:16]);
         ps_in = ps_ff + SUM_W'(rd_data[15:8]);
         ss_in = ss_ff + SUM_W'(rd_data[7:0]);
      end
   end

   // Sums over the rate divisor
   assign pr = PD'(rs_ff) * PD'(MD);
   assign pp = PD'(ps_ff) * PD'(MD);
   assign ps = PD'(ss_ff) * PD'(MD);
   always_comb begin
      qr_in = cmd.quot ? SUM_W'(pr >> KD) : qr_ff;
      qp_in = cmd.quot ? SUM_W'(pp >> KD) : qp_ff;
      qs_in = cmd.quot ? SUM_W'(ps >> KD) : qs_ff;
   end

   // Paper eats rock, scissors eat paper, rock eats scissors
   assign new_value = {
      rpsacu_pkg::apply_rate(centre_ff[23:16], qp_ff, qs_ff),
      rpsacu_pkg::apply_rate(centre_ff[15:8],  qs_ff, qr_ff),
      rpsacu_pkg::apply_rate(centre_ff[CHAN_W-1:0], qr_ff, qp_ff)
   };

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      if (cmd.result) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = idx_ff;
         rsp_value_in = new_value;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_index       = rsp_index_ff;
   assign rsp_value       = rsp_value_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff      <= 1'b0;
         av_ff        <= 1'b0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bank_ff      <= bank_in;
         av_ff        <= cmd.nbr_issue;
         rv_ff        <= av_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      y_ff         <= y_in;
      x_ff         <= x_in;
      addr_ff      <= addr_in;
      actr_ff      <= actr_in;
      rctr_ff      <= actr_ff;
      rs_ff        <= rs_in;
      ps_ff        <= ps_in;
      ss_ff        <= ss_in;
      centre_ff    <= centre_in;
      qr_ff        <= qr_in;
      qp_ff        <= qp_in;
      qs_ff        <= qs_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Checks
   `RPSACU_ASSERT_IMP(a_no_write_in_read,
      av_ff || rv_ff, !(cmd.load_we || cmd.result), "memory write during a neighbour read")
   `RPSACU_ASSERT_IMP(a_result_slot_free,
      cmd.result, !rsp_valid_ff || rsp_tready, "result overwrote a waiting item")
   `RPSACU_ASSERT_NXT(a_bank_only_on_commit,
      !cmd.commit, bank_ff == $past(bank_ff), "bank select changed without a commit")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the rock-paper-scissors cell update core.
`timescale 1ns / 1ps

module testbench;

   localparam int IDX_W       = rpsacu_pkg::IDX_W;
   localparam int CELL_W      = rpsacu_pkg::CELL_W;
   localparam int CHAN_W      = rpsacu_pkg::CHAN_W;
   localparam int FUNC_W      = rpsacu_pkg::FUNC_W;
   localparam int REQ_TDATA_W = rpsacu_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = rpsacu_pkg::RSP_TDATA_W;

   localparam int GRID_W      = 31;
   localparam int GRID_H      = 16;
   localparam int RATE_DIV    = 64;
   localparam int CELLS       = GRID_W * GRID_H;
   localparam int MAX_INDEX   = 2 ** IDX_W - 1;
   localparam int NBR_COUNT   = 9;
   localparam int CENTRE_READ = 9;
   localparam int CHAN_MAX    = 255;
   localparam int PER_PHASE   = 200;
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 40;
   localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [IDX_W-1:0]  index;
      logic [CELL_W-1:0] value;
   } cell_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  index;
      logic [CELL_W-1:0] value;
   } cell_rsp_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [FUNC_W-1:0]      req_tuser  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;

   cell_req_type pending_items [$];
   cell_rsp_type expected_cells [$];

   // predicted contents of both banks
   logic [CELL_W-1:0] cell_store [2][CELLS];
   logic              live_bank = 1'b0;

   // which cells the stimulus has filled, per bank
   bit gen_written [2][CELLS];
   bit gen_bank = 1'b0;

   logic req_taken    = 1'b0;
   int   idle_pct     = 0;
   int   stall_pct    = 0;
   int   useful_items = 0;
   int   failures     = 0;
   int   quiet_cycles = 0;

   rps_automaton_cell_update_core #(
      .GRID_WIDTH   (GRID_W),
      .GRID_HEIGHT  (GRID_H),
      .RATE_DIVISOR (RATE_DIV)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #10 clock = ~clock;

   // Cell read k of a compute on target: eight neighbours, (+1,+1) twice, then centre
   function automatic int read_index(input int target, input int k);
      int x, y, dx, dy;
      x = target % GRID_W;
      y = target / GRID_W;
      case (k)
         0, 1, 2: dx = -1;
         3, 4, CENTRE_READ: dx = 0;
         default: dx = 1;
      endcase
      case (k)
         0, 3, 5: dy = -1;
         1, 6, CENTRE_READ: dy = 0;
         default: dy = 1;
      endcase
      x = (x + dx + GRID_W) % GRID_W;
      y = (y + dy + GRID_H) % GRID_H;
      return x + y * GRID_W;
   endfunction

   // one channel: lose predator share, gain prey share, clamp
   function automatic logic [CHAN_W-1:0] settle_channel(input int chan, input int loss,
                                                        input int gain);
      int v;
      v = chan - loss / RATE_DIV + gain / RATE_DIV;
      if (v < 0) begin
         v = 0;
      end else if (v > CHAN_MAX) begin
         v = CHAN_MAX;
      end
      return v[CHAN_W-1:0];
   endfunction

   function automatic logic [CELL_W-1:0] next_cell_state(input int target);
      int                rock_sum, paper_sum, sciss_sum;
      logic [CELL_W-1:0] nb, centre;
      rock_sum  = 0;
      paper_sum = 0;
      sciss_sum = 0;
      for (int k = 0; k < NBR_COUNT; k++) begin
         nb = cell_store[live_bank][read_index(target, k)];
         rock_sum  += nb[23:16];
         paper_sum += nb[15:8];
         sciss_sum += nb[7:0];
      end
      centre = cell_store[live_bank][target];
      // paper eats rock, scissors eat paper, rock eats scissors
      return {settle_channel(centre[23:16], paper_sum, sciss_sum),
              settle_channel(centre[15:8], sciss_sum, rock_sum),
              settle_channel(centre[7:0], rock_sum, paper_sum)};
   endfunction

   // Update the predicted banks for one accepted item
   task automatic apply_request(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] index,
                                input logic [CELL_W-1:0] value);
      cell_rsp_type res;
      if (func == rpsacu_pkg::FN_COMMIT) begin
         live_bank = !live_bank;
      end else if (index < CELLS) begin
         if (func == rpsacu_pkg::FN_LOAD) begin
            cell_store[live_bank][index] = value;
         end else if (func == rpsacu_pkg::FN_COMPUTE) begin
            res.index = index;
            res.value = next_cell_state(index);
            cell_store[!live_bank][index] = res.value;
            expected_cells.push_back(res);
         end
      end
   endtask

   // channels biased towards the clamp limits
   function automatic logic [CELL_W-1:0] random_cell();
      logic [CELL_W-1:0] v;
      for (int c = 0; c < 3; c++) begin
         case ($urandom_range(3))
            0: v[c*CHAN_W +: CHAN_W] = '0;
            1: v[c*CHAN_W +: CHAN_W] = '1;
            default: v[c*CHAN_W +: CHAN_W] = CHAN_W'($urandom());
         endcase
      end
      return v;
   endfunction

   task automatic queue_item(input logic [FUNC_W-1:0] func, input int index,
                             input logic [CELL_W-1:0] value);
      cell_req_type it;
      it.func  = func;
      it.index = index[IDX_W-1:0];
      it.value = value;
      pending_items.push_back(it);
      if (func == rpsacu_pkg::FN_COMMIT) begin
         gen_bank = !gen_bank;
         useful_items++;
      end else if (func != FN_UNUSED && index < CELLS) begin
         if (func == rpsacu_pkg::FN_LOAD) begin
            gen_written[gen_bank][index] = 1'b1;
         end else begin
            gen_written[!gen_bank][index] = 1'b1;
         end
         useful_items++;
      end
   endtask

   // fill any unwritten cell that the compute reads, then compute
   task automatic queue_compute(input int target);
      int n;
      for (int k = 0; k <= CENTRE_READ; k++) begin
         n = read_index(target, k);
         if (!gen_written[gen_bank][n]) begin
            queue_item(rpsacu_pkg::FN_LOAD, n, random_cell());
         end
      end
      queue_item(rpsacu_pkg::FN_COMPUTE, target, CELL_W'($urandom()));
   endtask

   // Driver: items and ready change on the falling edge
   always @(negedge clock) begin
      cell_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         if (!req_tvalid || req_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
               nxt = pending_items.pop_front();
               req_tuser  <= nxt.func;
               req_tdata  <= {{(REQ_TDATA_W - IDX_W - CELL_W){1'b0}}, nxt.value, nxt.index};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin
      cell_rsp_type want;
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_request(req_tuser, req_tdata[IDX_W-1:0], req_tdata[IDX_W +: CELL_W]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_cells.size() == 0) begin
               $error("unexpected item: out_index %0d", rsp_tdata[IDX_W-1:0]);
               failures++;
            end else begin
               want = expected_cells.pop_front();
               if (rsp_tdata[IDX_W-1:0] !== want.index) begin
                  $error("out_index: expected %0d, got %0d", want.index, rsp_tdata[IDX_W-1:0]);
                  failures++;
               end
               if (rsp_tdata[IDX_W +: CELL_W] !== want.value) begin
                  $error("new_cell_value: expected %06h, got %06h", want.value,
                         rsp_tdata[IDX_W +: CELL_W]);
                  failures++;
               end
            end
         end
         // watchdog on cycles with no item moving
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      int ph, pick, goal, n;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 61; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 61; end
            default: begin idle_pct = 34; stall_pct = 34; end
         endcase

         if (ph == 0) begin
            // corner cell 0: paper-only neighbours drive rock to 0 and scissors to 255
            for (int k = 0; k < NBR_COUNT; k++) begin
               n = read_index(0, k);
               if (!gen_written[gen_bank][n]) queue_item(rpsacu_pkg::FN_LOAD, n, 24'h00FF00);
            end
            queue_item(rpsacu_pkg::FN_LOAD, 0, 24'h1080FF);
            queue_item(rpsacu_pkg::FN_COMPUTE, 0, '0);
            // opposite corner, wrapping both ways
            for (int k = 0; k <= CENTRE_READ; k++) begin
               n = read_index(CELLS - 1, k);
               if (!gen_written[gen_bank][n]) begin
                  queue_item(rpsacu_pkg::FN_LOAD, n, k[0] ? 24'hFFFFFF : 24'h000000);
               end
            end
            queue_item(rpsacu_pkg::FN_COMPUTE, CELLS - 1, 24'hFFFFFF);
            // out-of-range indexes and the spare function code are ignored
            queue_item(rpsacu_pkg::FN_LOAD, MAX_INDEX, 24'hFFFFFF);
            queue_item(rpsacu_pkg::FN_COMPUTE, CELLS, '0);
            queue_item(FN_UNUSED, MAX_INDEX, 24'hFFFFFF);
            // swap there and back, then recompute
            queue_item(rpsacu_pkg::FN_COMMIT, 0, '0);
            queue_item(rpsacu_pkg::FN_COMMIT, MAX_INDEX, '0);
            queue_item(rpsacu_pkg::FN_COMPUTE, 0, '0);
         end

         goal = useful_items + PER_PHASE;
         while (useful_items < goal) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               queue_compute($urandom_range(CELLS - 1));
            end else if (pick < 82) begin
               queue_item(rpsacu_pkg::FN_LOAD, $urandom_range(CELLS - 1), random_cell());
            end else if (pick < 88) begin
               queue_item(rpsacu_pkg::FN_COMMIT, $urandom_range(MAX_INDEX),
                          CELL_W'($urandom()));
            end else if (pick < 95) begin
               queue_item($urandom_range(1) ? rpsacu_pkg::FN_LOAD : rpsacu_pkg::FN_COMPUTE,
                          $urandom_range(MAX_INDEX, CELLS), CELL_W'($urandom()));
            end else begin
               queue_item(FN_UNUSED, $urandom_range(MAX_INDEX), CELL_W'($urandom()));
            end
         end

         while (pending_items.size() != 0 || req_tvalid || expected_cells.size() != 0) begin
            @(posedge clock);
         end
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_cells.size() != 0) begin
         $error("%0d expected items never arrived", expected_cells.size());
         failures++;
      end
      if (failures == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
